// ===== hw/rtl/integer_alu_with_condition_codes_defines.svh =====
// Assertion macros for the integer ALU
`ifndef INTEGER_ALU_WITH_CONDITION_CODES_DEFINES_SVH
`define INTEGER_ALU_WITH_CONDITION_CODES_DEFINES_SVH
`ifndef SYNTHESIS
`define ALU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("alu check failed");
`define ALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("alu check failed");
`else
`define ALU_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/ialu_cc_pkg.sv =====
// Operation and condition codes for the integer ALU
package ialu_cc_pkg;
	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,  OP_ADDX = 5'd1,  OP_ABCD = 5'd2,  OP_SUB  = 5'd3,
		OP_SUBX = 5'd4,  OP_SBCD = 5'd5,  OP_CMP  = 5'd6,  OP_AND  = 5'd7,
		OP_OR   = 5'd8,  OP_EOR  = 5'd9,  OP_NOT  = 5'd10, OP_ASL  = 5'd11,
		OP_ASR  = 5'd12, OP_LSL  = 5'd13, OP_LSR  = 5'd14, OP_ROL  = 5'd15,
		OP_ROR  = 5'd16, OP_ROXL = 5'd17, OP_ROXR = 5'd18, OP_BCHG = 5'd19,
		OP_BSET = 5'd20, OP_BCLR = 5'd21, OP_BTST = 5'd22, OP_COND = 5'd23
	} op_t;

	typedef enum logic [3:0] {
		CC_T  = 4'd0,  CC_F  = 4'd1,  CC_HI = 4'd2,  CC_LS = 4'd3,
		CC_CC = 4'd4,  CC_CS = 4'd5,  CC_NE = 4'd6,  CC_EQ = 4'd7,
		CC_VC = 4'd8,  CC_VS = 4'd9,  CC_PL = 4'd10, CC_MI = 4'd11,
		CC_GE = 4'd12, CC_LT = 4'd13, CC_GT = 4'd14, CC_LE = 4'd15
	} cond_t;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0, SZ_WORD = 2'd1, SZ_LONG = 2'd2, SZ_ALT = 2'd3
	} size_t;

	typedef struct packed {
		logic x;
		logic n;
		logic z;
		logic v;
		logic c;
	} flags_t;

	localparam int unsigned InDataW  = 80;
	localparam int unsigned InUserW  = 7;
	localparam int unsigned OutDataW = 40;
endpackage

// ===== hw/rtl/integer_alu_with_condition_codes.sv =====
// Integer ALU with 68000-style condition codes, top level
//
// One request carries an operation code and operand size in s_tuser and the operands,
// shift count, bit number and branch condition in s_tdata. The block registers the
// request, works it out in one pass of logic (adder, BCD correction, barrel shifter
// and rotator, bit mask, condition decode) and registers the result together with the
// updated X,N,Z,V,C flags. One request is taken every cycle while the master side does
// not stall, and the result passes the input and result registers to m_tdata. The flag register
// is written as a request moves into the result register, so the following request
// already sees the new flags and no bubble is needed between dependent operations. A
// stalled master side holds both stages; s_tready drops only when both hold a request.
// Flags reset to zero.
`include "integer_alu_with_condition_codes_defines.svh"
module integer_alu_with_condition_codes
	import ialu_cc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [31:0] operand_a, [63:32] operand_b, [69:64] shift_count,
	// [74:70] bit_number, [78:75] condition, [79] zero
	input  logic [InDataW-1:0]  s_tdata,
	// [4:0] mode, [6:5] op_size
	input  logic [InUserW-1:0]  s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [31:0] result, [36:32] flags_out, [37] condition_true, [39:38] zero
	output logic [OutDataW-1:0] m_tdata
);

	// input stage
	logic        valid_s1;
	logic [4:0]  mode_s1;
	logic [1:0]  size_s1;
	logic [31:0] opa_s1, opb_s1;
	logic [5:0]  cnt_s1;
	logic [4:0]  bitn_s1;
	logic [3:0]  cond_s1;

	// result stage
	logic        valid_s2;
	logic [31:0] result_s2;
	flags_t      flags_s2;
	logic        ctrue_s2;

	flags_t      flags_q;

	logic adv_s1, take_in;

	// advance into the result register whenever it is free or being drained
	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			opa_s1  <= s_tdata[31:0];
			opb_s1  <= s_tdata[63:32];
			cnt_s1  <= s_tdata[69:64];
			bitn_s1 <= s_tdata[74:70];
			cond_s1 <= s_tdata[78:75];
			mode_s1 <= s_tuser[4:0];
			size_s1 <= s_tuser[6:5];
		end
	end

	// ---- size decode ----
	logic [5:0]  w;
	logic [31:0] m, msbm;

	always_comb begin
		case (size_s1)
			SZ_BYTE: begin
				w = 6'd8;
				m = 32'h0000_00FF;
			end
			SZ_WORD: begin
				w = 6'd16;
				m = 32'h0000_FFFF;
			end
			default: begin
				w = 6'd32;
				m = 32'hFFFF_FFFF;
			end
		endcase
		msbm = m ^ (m >> 1);
	end

	logic [31:0] a, b;
	assign a = opa_s1 & m;
	assign b = opb_s1 & m;

	// ---- add / subtract ----
	logic [32:0] sum, dif, cmpd, arr;
	logic [32:0] arr_sh;
	logic        xin;

	assign xin  = flags_q.x;
	assign sum  = {1'b0, a} + {1'b0, b} + {32'd0, (mode_s1 == OP_ADDX) && xin};
	assign dif  = {1'b0, b} - {1'b0, a} - {32'd0, (mode_s1 == OP_SUBX) && xin};
	assign cmpd = {1'b0, a} - {1'b0, b};

	always_comb begin
		case (mode_s1)
			OP_ADD, OP_ADDX: arr = sum;
			OP_CMP:          arr = cmpd;
			default:         arr = dif;
		endcase
		arr_sh = arr >> w;
	end

	// ---- BCD ----
	logic [9:0]  abcd_lo, abcd_hi, abcd_t, abcd_r1, abcd_r;
	logic        abcd_c;
	logic [15:0] sb_lo, sb_hi, sb_t, sb_r1, sb_r, sb_full, sb_cv;
	logic [3:0]  sb_bcd;
	logic [7:0]  bcd_r;
	logic        bcd_c, bcd_v;

	always_comb begin
		abcd_lo = {6'd0, opa_s1[3:0]} + {6'd0, opb_s1[3:0]} + {9'd0, xin};
		abcd_hi = {2'd0, opa_s1[7:4], 4'd0} + {2'd0, opb_s1[7:4], 4'd0};
		abcd_t  = abcd_hi + abcd_lo;
		abcd_r1 = (abcd_lo > 10'd9) ? abcd_t + 10'h6 : abcd_t;
		abcd_c  = (abcd_r1 & 10'h3F0) > 10'h90;
		abcd_r  = abcd_c ? abcd_r1 + 10'h60 : abcd_r1;

		sb_lo   = {12'd0, opb_s1[3:0]} - {12'd0, opa_s1[3:0]} - {15'd0, xin};
		sb_hi   = {8'd0, opb_s1[7:4], 4'd0} - {8'd0, opa_s1[7:4], 4'd0};
		sb_t    = sb_hi + sb_lo;
		sb_bcd  = (sb_lo[7:4] != 4'd0) ? 4'd6 : 4'd0;
		sb_r1   = sb_t - {12'd0, sb_bcd};
		sb_full = {8'd0, opb_s1[7:0]} - {8'd0, opa_s1[7:0]} - {15'd0, xin};
		sb_r    = sb_full[8] ? sb_r1 - 16'h60 : sb_r1;
		sb_cv   = sb_full - {12'd0, sb_bcd};

		if (mode_s1 == OP_ABCD) begin
			bcd_r = abcd_r[7:0];
			bcd_c = abcd_c;
			bcd_v = !abcd_t[7] && abcd_r[7];
		end else begin
			bcd_r = sb_r[7:0];
			bcd_c = sb_cv[9:8] != 2'd0;
			bcd_v = sb_t[7] && !sb_r[7];
		end
	end

	// ---- barrel shifter and rotator ----
	logic [94:0]  lsl_w;
	logic [32:0]  lsr_w;
	logic [95:0]  asr_se;
	logic [96:0]  asr_c;
	logic [31:0]  topmask, topsel;
	logic [63:0]  top64;
	logic [4:0]   krot;
	logic [63:0]  dbl;
	logic [95:0]  rol_w;
	logic [63:0]  ror_w;
	logic [5:0]   kx, wp1;
	logic [32:0]  ring, mw1, xring;
	logic [65:0]  dbl_x;
	logic [98:0]  roxl_w;
	logic [65:0]  roxr_w;
	logic [31:0]  sh_r;
	logic         sh_c, sh_v;

	always_comb begin
		lsl_w   = {63'd0, a} << cnt_s1;
		lsr_w   = {a, 1'b0} >> cnt_s1;
		asr_se  = {64'd0, a} | ({96{(a & msbm) != 32'd0}} & ~{64'd0, m});
		asr_c   = {asr_se, 1'b0} >> cnt_s1;
		top64   = {32'd0, m} >> ({1'b0, cnt_s1} + 7'd1);
		topmask = ~top64[31:0] & m;
		topsel  = a & topmask;

		krot    = cnt_s1[4:0] & (w[4:0] - 5'd1);
		dbl     = ({32'd0, a} << w) | {32'd0, a};
		rol_w   = ({32'd0, dbl} << krot) >> w;
		ror_w   = dbl >> krot;

		wp1 = w + 6'd1;
		kx  = cnt_s1;
		for (int i = 0; i < 7; i++) begin
			if (kx >= wp1) begin
				kx = kx - wp1;
			end
		end
		mw1    = ({1'b0, m} << 1) | 33'd1;
		ring   = {1'b0, a} | ({32'd0, xin} << w);
		dbl_x  = ({33'd0, ring} << wp1) | {33'd0, ring};
		roxl_w = ({33'd0, dbl_x} << kx) >> wp1;
		roxr_w = dbl_x >> kx;

		sh_v  = 1'b0;
		xring = 33'd0;
		case (mode_s1)
			OP_ASL, OP_LSL: begin
				sh_r = lsl_w[31:0] & m;
				sh_c = lsl_w[w];
				if (mode_s1 == OP_ASL) begin
					sh_v = (topsel != 32'd0) && ((topsel != topmask) || (cnt_s1 >= w));
				end
			end
			OP_ASR: begin
				sh_r = asr_c[32:1] & m;
				sh_c = asr_c[0];
			end
			OP_LSR: begin
				sh_r = lsr_w[32:1];
				sh_c = lsr_w[0];
			end
			OP_ROL: begin
				sh_r = rol_w[31:0] & m;
				sh_c = (cnt_s1 != 6'd0) && rol_w[0];
			end
			OP_ROR: begin
				sh_r = ror_w[31:0] & m;
				sh_c = (cnt_s1 != 6'd0) && ((sh_r & msbm) != 32'd0);
			end
			OP_ROXL: begin
				xring = roxl_w[32:0] & mw1;
				sh_r  = xring[31:0] & m;
				sh_c  = (xring & ({32'd0, 1'b1} << w)) != 33'd0;
			end
			default: begin
				xring = roxr_w[32:0] & mw1;
				sh_r  = xring[31:0] & m;
				sh_c  = (xring & ({32'd0, 1'b1} << w)) != 33'd0;
			end
		endcase
	end

	// ---- bit operations ----
	logic [31:0] bmask;
	assign bmask = 32'd1 << bitn_s1;

	// ---- condition decode ----
	logic ct;
	always_comb begin
		case (cond_s1)
			CC_T:    ct = 1'b1;
			CC_F:    ct = 1'b0;
			CC_HI:   ct = !flags_q.c && !flags_q.z;
			CC_LS:   ct = flags_q.c || flags_q.z;
			CC_CC:   ct = !flags_q.c;
			CC_CS:   ct = flags_q.c;
			CC_NE:   ct = !flags_q.z;
			CC_EQ:   ct = flags_q.z;
			CC_VC:   ct = !flags_q.v;
			CC_VS:   ct = flags_q.v;
			CC_PL:   ct = !flags_q.n;
			CC_MI:   ct = flags_q.n;
			CC_GE:   ct = flags_q.n == flags_q.v;
			CC_LT:   ct = flags_q.n != flags_q.v;
			CC_GT:   ct = (flags_q.n == flags_q.v) && !flags_q.z;
			default: ct = (flags_q.n != flags_q.v) || flags_q.z;
		endcase
	end

	// ---- result and flag selection ----
	logic [31:0] r_nx;
	flags_t      f_nx;
	logic        ct_nx;

	always_comb begin
		r_nx  = 32'd0;
		f_nx  = flags_q;
		ct_nx = 1'b0;
		case (mode_s1)
			OP_ADD, OP_ADDX, OP_SUB, OP_SUBX, OP_CMP: begin
				r_nx = arr[31:0] & m;
				case (mode_s1)
					OP_ADD, OP_ADDX: f_nx.v = ((a ^ r_nx) & (b ^ r_nx) & msbm) != 32'd0;
					OP_CMP:          f_nx.v = ((a ^ b) & (a ^ r_nx) & msbm) != 32'd0;
					default:         f_nx.v = ((a ^ b) & (b ^ r_nx) & msbm) != 32'd0;
				endcase
				f_nx.c = arr_sh[0];
				if (mode_s1 != OP_CMP) begin
					f_nx.x = arr_sh[0];
				end
				if (mode_s1 == OP_ADDX || mode_s1 == OP_SUBX) begin
					if (r_nx != 32'd0) begin
						f_nx.z = 1'b0;
					end
				end else begin
					f_nx.z = r_nx == 32'd0;
				end
				f_nx.n = (r_nx & msbm) != 32'd0;
			end
			OP_ABCD, OP_SBCD: begin
				r_nx   = {24'd0, bcd_r} & m;
				f_nx.c = bcd_c;
				f_nx.x = bcd_c;
				f_nx.v = bcd_v;
				f_nx.n = bcd_r[7];
				if (bcd_r != 8'd0) begin
					f_nx.z = 1'b0;
				end
			end
			OP_AND, OP_OR, OP_EOR, OP_NOT: begin
				case (mode_s1)
					OP_AND:  r_nx = a & b;
					OP_OR:   r_nx = a | b;
					OP_EOR:  r_nx = a ^ b;
					default: r_nx = ~a & m;
				endcase
				f_nx.c = 1'b0;
				f_nx.v = 1'b0;
				f_nx.n = (r_nx & msbm) != 32'd0;
				f_nx.z = r_nx == 32'd0;
			end
			OP_ASL, OP_ASR, OP_LSL, OP_LSR, OP_ROL, OP_ROR, OP_ROXL, OP_ROXR: begin
				r_nx   = sh_r;
				f_nx.c = sh_c;
				f_nx.v = sh_v;
				// ROL/ROR keep X; plain shifts move it only on a nonzero count
				if (mode_s1 == OP_ROXL || mode_s1 == OP_ROXR ||
				    ((mode_s1 == OP_ASL || mode_s1 == OP_ASR || mode_s1 == OP_LSL ||
				      mode_s1 == OP_LSR) && cnt_s1 != 6'd0)) begin
					f_nx.x = sh_c;
				end
				f_nx.n = (sh_r & msbm) != 32'd0;
				f_nx.z = sh_r == 32'd0;
			end
			OP_BCHG, OP_BSET, OP_BCLR, OP_BTST: begin
				f_nx.z = (a & bmask) == 32'd0;
				case (mode_s1)
					OP_BCHG: r_nx = (a ^ bmask) & m;
					OP_BSET: r_nx = (a | bmask) & m;
					OP_BCLR: r_nx = a & ~bmask;
					default: r_nx = a;
				endcase
			end
			OP_COND: begin
				ct_nx = ct;
			end
			default: begin
				r_nx = 32'd0;
			end
		endcase
	end

	// move into the result register and commit the flags in the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				flags_q <= f_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			result_s2 <= r_nx;
			flags_s2  <= f_nx;
			ctrue_s2  <= ct_nx;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, ctrue_s2, flags_s2, result_s2};

	// ---- checks ----
	`ALU_ASSERT_NEXT(a_cond_keeps_flags, clk, arst_n, adv_s1 && valid_s1 && mode_s1 == OP_COND, flags_q == $past(flags_q))
	`ALU_ASSERT_NEXT(a_ctrue_only_cond, clk, arst_n, adv_s1 && valid_s1 && mode_s1 != OP_COND, !ctrue_s2)
	`ALU_ASSERT_SAME(a_stall_full, clk, arst_n, !s_tready, valid_s1 && valid_s2 && !m_tready)
	`ALU_ASSERT_NEXT(a_flags_follow, clk, arst_n, adv_s1 && valid_s1, flags_q == flags_s2)

endmodule
